// ===== sv/triangle_area_and_normal_top_defines.svh =====
// Assertion macros shared by the triangle area and normal block.
`ifndef TRIANGLE_AREA_AND_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_AREA_AND_NORMAL_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define TAN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define TAN_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/tan_pkg.sv =====
// Widths and item types of the triangle area and normal block.
`timescale 1ns / 1ps
package tan_pkg;

    localparam int IN_W     = 16;
    localparam int NUM_IN   = 9;
    localparam int IN_BUS_W = IN_W * NUM_IN;
    localparam int E_W      = IN_W + 1;
    localparam int P_W      = 2 * E_W;
    localparam int N_W      = P_W + 2;
    localparam int MAG_W    = N_W - 1;
    localparam int LO_W     = 18;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int HH_W     = 2 * HI_W;
    localparam int HL_W     = HI_W + LO_W;
    localparam int LL_W     = 2 * LO_W;
    localparam int S_W      = 72;
    localparam int EPS_W    = 16;
    localparam int EPS_SQ_W = 2 * EPS_W;
    localparam int ROOT_W   = 35;
    localparam int FRAC_W   = 14;
    localparam int Q_W      = FRAC_W + 1;
    localparam int DIV_W    = MAG_W + FRAC_W + 1;
    localparam int AREA_W   = 36;
    localparam int OUT_W    = 16;
    localparam int FRONT_STAGES = 8;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;
    localparam logic [EPS_SQ_W-1:0] EPS_SQ_RESET = EPS_SQ_W'(1);

    // Cross product of one triangle as sign and magnitude per component.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic                  degen;
    } tan_vec_t;

    // Item travelling through the square root cells.
    typedef struct packed {
        tan_vec_t          vec;
        logic [ROOT_W-1:0] root;
        logic [S_W-1:0]    rem;
    } tan_sq_t;

    // Item travelling through the divider cells.
    typedef struct packed {
        logic [2:0]            neg;
        logic                  degen;
        logic [ROOT_W-1:0]     root;
        logic [2:0][Q_W-1:0]   quo;
        logic [2:0][DIV_W-1:0] rem;
    } tan_dv_t;

endpackage

// ===== sv/tan_front.sv =====
// Edge vectors, cross product, squared norm and degenerate test, pipelined.
`timescale 1ns / 1ps
module tan_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tan_pkg::IN_BUS_W-1:0]  in_data,
    input  logic [tan_pkg::EPS_SQ_W-1:0]  eps_sq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tan_pkg::tan_vec_t             out_vec,
    output logic [tan_pkg::S_W-1:0]       out_s
);

    localparam int NS = tan_pkg::FRONT_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic signed [tan_pkg::E_W-1:0] e_reg [6];
    logic signed [tan_pkg::E_W-1:0] e_next [6];
    logic signed [tan_pkg::P_W-1:0] p_reg [6];
    logic signed [tan_pkg::N_W-1:0] n_reg [3];
    logic [2:0][tan_pkg::HH_W-1:0]  hh_reg;
    logic [2:0][tan_pkg::HL_W-1:0]  hl_reg;
    logic [2:0][tan_pkg::LL_W-1:0]  ll_reg;
    logic [2:0][tan_pkg::S_W-1:0]   sq_reg;
    logic [tan_pkg::S_W-1:0]        s_reg;
    logic [tan_pkg::S_W-1:0]        s8_reg;
    tan_pkg::tan_vec_t              vec_reg [4:8];
    tan_pkg::tan_vec_t              vec_next;

    // Stall chain: a stage loads when it is empty or its successor moves.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_vec   = vec_reg[8];
    assign out_s     = s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Edge vectors B - A and C - A.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            e_next[c] = $signed({in_data[(c+4)*tan_pkg::IN_W-1],
                                 in_data[(c+3)*tan_pkg::IN_W +: tan_pkg::IN_W]})
                      - $signed({in_data[(c+1)*tan_pkg::IN_W-1],
                                 in_data[c*tan_pkg::IN_W +: tan_pkg::IN_W]});
            e_next[c+3] = $signed({in_data[(c+7)*tan_pkg::IN_W-1],
                                   in_data[(c+6)*tan_pkg::IN_W +: tan_pkg::IN_W]})
                        - $signed({in_data[(c+1)*tan_pkg::IN_W-1],
                                   in_data[c*tan_pkg::IN_W +: tan_pkg::IN_W]});
        end
    end

    // Sign and magnitude of the cross product components.
    always_comb
    begin
        logic [tan_pkg::N_W-1:0] absn;
        vec_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            vec_next.neg[c] = n_reg[c][tan_pkg::N_W-1];
            absn = n_reg[c][tan_pkg::N_W-1] ? (tan_pkg::N_W'(0) - n_reg[c]) : n_reg[c];
            vec_next.mag[c] = absn[tan_pkg::MAG_W-1:0];
        end
    end

    // Data stages, loaded whenever their stage moves.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 6; k++)
            begin
                e_reg[k] <= e_next[k];
            end
        end
        if (en[1])
        begin
            p_reg[0] <= e_reg[1] * e_reg[5];
            p_reg[1] <= e_reg[2] * e_reg[4];
            p_reg[2] <= e_reg[2] * e_reg[3];
            p_reg[3] <= e_reg[0] * e_reg[5];
            p_reg[4] <= e_reg[0] * e_reg[4];
            p_reg[5] <= e_reg[1] * e_reg[3];
        end
        if (en[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c] <= $signed({{2{p_reg[2*c][tan_pkg::P_W-1]}}, p_reg[2*c]})
                          - $signed({{2{p_reg[2*c+1][tan_pkg::P_W-1]}}, p_reg[2*c+1]});
            end
        end
        if (en[3])
        begin
            vec_reg[4] <= vec_next;
        end
        // Squares split into partial products of at most 18 bits a side.
        if (en[4])
        begin
            vec_reg[5] <= vec_reg[4];
            for (int c = 0; c < 3; c++)
            begin
                hh_reg[c] <= vec_reg[4].mag[c][tan_pkg::MAG_W-1:tan_pkg::LO_W]
                           * vec_reg[4].mag[c][tan_pkg::MAG_W-1:tan_pkg::LO_W];
                hl_reg[c] <= vec_reg[4].mag[c][tan_pkg::MAG_W-1:tan_pkg::LO_W]
                           * vec_reg[4].mag[c][tan_pkg::LO_W-1:0];
                ll_reg[c] <= vec_reg[4].mag[c][tan_pkg::LO_W-1:0]
                           * vec_reg[4].mag[c][tan_pkg::LO_W-1:0];
            end
        end
        if (en[5])
        begin
            vec_reg[6] <= vec_reg[5];
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= (tan_pkg::S_W'(hh_reg[c]) << (2 * tan_pkg::LO_W))
                           + (tan_pkg::S_W'(hl_reg[c]) << (tan_pkg::LO_W + 1))
                           + tan_pkg::S_W'(ll_reg[c]);
            end
        end
        if (en[6])
        begin
            vec_reg[7] <= vec_reg[6];
            s_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
        // Degenerate when the squared norm does not exceed epsilon squared.
        if (en[7])
        begin
            vec_reg[8] <= {vec_reg[7].neg, vec_reg[7].mag,
                           (s_reg <= tan_pkg::S_W'(eps_sq))};
            s8_reg     <= s_reg;
        end
    end

endmodule

// ===== sv/tan_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the root.
`timescale 1ns / 1ps
module tan_sqrt_cell
#(
    parameter int BIT = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tan_pkg::tan_sq_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output tan_pkg::tan_sq_t  out_item
);

    logic             valid_reg;
    tan_pkg::tan_sq_t item_reg;
    tan_pkg::tan_sq_t item_next;
    logic [tan_pkg::S_W-1:0] trial;

    // Setting this bit grows the square by root * 2^(BIT+1) + 2^(2*BIT).
    always_comb
    begin
        trial = (tan_pkg::S_W'(in_item.root) << (BIT + 1))
              | (tan_pkg::S_W'(1) << (2 * BIT));
        item_next = in_item;
        if (in_item.rem >= trial)
        begin
            item_next.rem  = in_item.rem - trial;
            item_next.root = in_item.root | (tan_pkg::ROOT_W'(1) << BIT);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/tan_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit of all three lanes.
`timescale 1ns / 1ps
module tan_div_cell
#(
    parameter int BIT = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tan_pkg::tan_dv_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output tan_pkg::tan_dv_t  out_item
);

    logic             valid_reg;
    tan_pkg::tan_dv_t item_reg;
    tan_pkg::tan_dv_t item_next;
    logic [tan_pkg::DIV_W-1:0] trial;

    // Restoring step against the shifted divisor, one lane per component.
    always_comb
    begin
        trial     = tan_pkg::DIV_W'(in_item.root) << BIT;
        item_next = in_item;
        for (int c = 0; c < 3; c++)
        begin
            if (in_item.rem[c] >= trial)
            begin
                item_next.rem[c] = in_item.rem[c] - trial;
                item_next.quo[c] = in_item.quo[c] | (tan_pkg::Q_W'(1) << BIT);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/triangle_area_and_normal_top.sv =====
// Top level of the triangle area and unit normal block.
//
//   Channel   Direction  Signals                      Contents
//   s_axis    in         s_tvalid s_tready s_tdata    ax ay az bx by bz cx cy cz
//   m_axis    out        m_tvalid m_tready m_tdata    area normal_x normal_y normal_z
//                        m_tuser                      degenerate
//   cfg       in         cfg_valid cfg_ready cfg_data eps_threshold
//
// One triangle is accepted per cycle unless a stall backs up to the input.
// The pipeline is 8 front stages, 35 square root cells (one root bit each),
// one divider setup stage, 15 divider cells (one quotient bit each) and the
// output register. Reset empties every stage; eps_threshold resets to 1.
// Each stage holds its request only while its successor is full and stalled,
// so bubbles close up and input is taken while a result waits at the output.
`timescale 1ns / 1ps
`include "triangle_area_and_normal_top_defines.svh"
module triangle_area_and_normal_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // area[35:0], normal_x, normal_y, normal_z, zero pad
    output logic [0:0]   m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // eps_threshold
);

    localparam int RW = tan_pkg::ROOT_W;
    localparam int QW = tan_pkg::Q_W;

    // Epsilon squared, kept ready for the degenerate compare.
    logic [tan_pkg::EPS_SQ_W-1:0] eps_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_sq_reg <= tan_pkg::EPS_SQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_sq_reg <= cfg_data * cfg_data;
        end
    end

    // Front pipeline.
    logic              fr_valid;
    tan_pkg::tan_vec_t fr_vec;
    logic [tan_pkg::S_W-1:0] fr_s;

    logic             sq_v [RW+1];
    logic             sq_r [RW+1];
    tan_pkg::tan_sq_t sq_item [RW+1];

    tan_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .eps_sq    (eps_sq_reg),
        .out_valid (fr_valid),
        .out_ready (sq_r[0]),
        .out_vec   (fr_vec),
        .out_s     (fr_s)
    );

    assign sq_v[0]         = fr_valid;
    assign sq_item[0].vec  = fr_vec;
    assign sq_item[0].root = '0;
    assign sq_item[0].rem  = fr_s;

    // Square root chain, most significant root bit first.
    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        tan_sqrt_cell #(.BIT(RW - 1 - g)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[g]),
            .in_ready  (sq_r[g]),
            .in_item   (sq_item[g]),
            .out_valid (sq_v[g+1]),
            .out_ready (sq_r[g+1]),
            .out_item  (sq_item[g+1])
        );
    end

    // Divider setup: dividend is |v| * 2^14 + norm / 2.
    logic             dv_v [QW+1];
    logic             dv_r [QW+1];
    tan_pkg::tan_dv_t dv_item [QW+1];
    logic             prep_valid_reg;
    tan_pkg::tan_dv_t prep_reg;
    tan_pkg::tan_dv_t prep_next;

    always_comb
    begin
        prep_next       = '0;
        prep_next.neg   = sq_item[RW].vec.neg;
        prep_next.degen = sq_item[RW].vec.degen;
        prep_next.root  = sq_item[RW].root;
        for (int c = 0; c < 3; c++)
        begin
            prep_next.rem[c] = (tan_pkg::DIV_W'(sq_item[RW].vec.mag[c]) << tan_pkg::FRAC_W)
                             + tan_pkg::DIV_W'(sq_item[RW].root >> 1);
        end
    end

    assign sq_r[RW] = !prep_valid_reg || dv_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (sq_r[RW])
        begin
            prep_valid_reg <= sq_v[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_r[RW])
        begin
            prep_reg <= prep_next;
        end
    end

    assign dv_v[0]    = prep_valid_reg;
    assign dv_item[0] = prep_reg;

    // Divider chain, most significant quotient bit first.
    for (genvar g = 0; g < QW; g++)
    begin : g_div
        tan_div_cell #(.BIT(QW - 1 - g)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[g]),
            .in_ready  (dv_r[g]),
            .in_item   (dv_item[g]),
            .out_valid (dv_v[g+1]),
            .out_ready (dv_r[g+1]),
            .out_item  (dv_item[g+1])
        );
    end

    // Output register: clamp, apply sign, zero the normal when degenerate.
    logic                          out_valid_reg;
    logic [tan_pkg::AREA_W-1:0]    area_reg;
    logic [2:0][tan_pkg::OUT_W-1:0] nrm_reg;
    logic                          degen_reg;
    logic [2:0][tan_pkg::OUT_W-1:0] nrm_next;

    always_comb
    begin
        logic [QW-1:0] q;
        for (int c = 0; c < 3; c++)
        begin
            q = (dv_item[QW].quo[c] > tan_pkg::Q_ONE) ? tan_pkg::Q_ONE : dv_item[QW].quo[c];
            if (dv_item[QW].degen)
            begin
                nrm_next[c] = '0;
            end
            else if (dv_item[QW].neg[c])
            begin
                nrm_next[c] = tan_pkg::OUT_W'(0) - tan_pkg::OUT_W'(q);
            end
            else
            begin
                nrm_next[c] = tan_pkg::OUT_W'(q);
            end
        end
    end

    assign dv_r[QW] = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_r[QW])
        begin
            out_valid_reg <= dv_v[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_r[QW])
        begin
            area_reg  <= tan_pkg::AREA_W'(dv_item[QW].root >> 1);
            nrm_reg   <= nrm_next;
            degen_reg <= dv_item[QW].degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, nrm_reg[2], nrm_reg[1], nrm_reg[0], area_reg};
    assign m_tuser  = degen_reg;

    // A degenerate result carries a zero normal.
    `TAN_ASSERT_IMP(a_degen_zero_normal, m_tvalid && m_tuser[0], nrm_reg == '0,
        "degenerate result with nonzero normal")

    // The x component of the unit normal never leaves [-1, 1] in Q1.14.
    `TAN_ASSERT_NEVER(a_normal_x_range,
        m_tvalid && ($signed(nrm_reg[0]) > 16'sd16384 || $signed(nrm_reg[0]) < -16'sd16384),
        "normal_x outside unit range")

    // Input is refused only when every stage is full behind a stalled output.
    `TAN_ASSERT_IMP(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready,
        "input refused while the pipeline has room")

    // A zero root means a zero squared norm, which is always degenerate.
    `TAN_ASSERT_IMP(a_zero_root_degen, sq_v[RW] && sq_item[RW].root == '0,
        sq_item[RW].vec.degen, "zero norm not flagged degenerate")

endmodule
